// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Concurrent assertions clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication check: prop is a full property expression
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Hold check: while cond is true, sig keeps its value into the next cycle
`define CHK_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, symbol codes and the sequencer state type of the
// postfix evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_pkg;

    // Operand stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // Operand word width and divider step counter width
    localparam int WORD_W = 8;
    localparam int CNT_W  = $clog2(WORD_W);

    // Symbol codes
    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POPR,
        S_POPL,
        S_CALC,
        S_DIV,
        S_PUSH,
        S_FPOP,
        S_EMIT
    } rpn_state_t;

    // True for the four operator bytes
    function automatic logic is_operator(input logic [7:0] sym);
        is_operator = (sym == SYM_ADD) || (sym == SYM_SUB) ||
                      (sym == SYM_MUL) || (sym == SYM_DIV);
    endfunction

endpackage

// ===== rtl/rpn_stack_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rpn_divider.sv =====
// ----------------------------------------------------------------------------
// rpn_divider
// Iterative signed 8-bit divider, one quotient bit per cycle on the
// magnitudes; quotient truncates toward zero and wraps to 8 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_divider
    import rpn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WORD_W-1:0] dividend,
    input  logic signed [WORD_W-1:0] divisor,
    output logic                     done,
    output logic signed [WORD_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic              neg_reg;

    logic [WORD_W-1:0] dvd_mag;
    logic [WORD_W-1:0] dvs_mag;
    logic [WORD_W-1:0] trial;
    logic              fits;

    // Operand magnitudes; the most negative value maps to its unsigned twin
    assign dvd_mag = dividend[WORD_W-1] ? WORD_W'(-dividend) : dividend;
    assign dvs_mag = divisor[WORD_W-1]  ? WORD_W'(-divisor)  : divisor;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign fits  = (trial >= dvs_reg);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dvd_mag;
            dvs_reg <= dvs_mag;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? WORD_W'(trial - dvs_reg) : trial;
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? WORD_W'(-quo_reg) : quo_reg;

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish evaluator over an 8-bit operand stack held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one postfix symbol byte per item in s_tdata, with
//   s_tlast on the final symbol of an expression. Operators + - * / pop two
//   operands and push the result; any other byte pushes (byte - 48).
//   Output channel m_*: one item per expression, sent after the last symbol,
//   holding the popped answer in m_tdata and the sticky underflow, overflow
//   and divide-by-zero flags in m_tuser. The stack and flags then clear.
// Timing:
//   A push symbol goes straight to the push state; an add, subtract or
//   multiply pops the right and then the left operand, computes and pushes;
//   a divide by a non-zero divisor also waits on the bit-serial divider (8
//   steps, then its done strobe); a zero divisor skips the divider. Each stack
//   pop is one RAM read. A last symbol adds the final pop and the output
//   load. One symbol is worked on at a time.
// Reset:
//   rst_n clears the stack pointer, the flags and the output valid; the
//   stack RAM itself is not cleared, only entries pushed since are read.
// Stall:
//   A result waits in the output register while m_tready is low; new symbols
//   are still taken, and only a further result holds until it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator
    import rpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value
    output logic [2:0] m_tuser    // [0] underflow, [1] overflow, [2] divide_by_zero
);

    rpn_state_t state_reg, state_next;

    logic [SP_W-1:0]          sp_reg;
    logic                     uf_reg;
    logic                     of_reg;
    logic                     dz_reg;
    logic                     pend_reg;
    logic                     out_valid_reg;

    logic [7:0]               sym_reg;
    logic                     last_reg;
    logic signed [WORD_W-1:0] right_reg;
    logic [WORD_W-1:0]        result_reg;
    logic [WORD_W-1:0]        out_value_reg;
    logic [2:0]               out_flags_reg;

    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [WORD_W-1:0]        rd_data;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     div_start;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_q;

    logic                     sp_empty;
    logic                     sp_full;
    logic [SP_W-1:0]          sp_dec;
    logic signed [WORD_W-1:0] popped;
    logic signed [2*WORD_W-1:0] product;
    logic                     out_free;

    assign sp_empty = (sp_reg == '0);
    assign sp_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign sp_dec   = sp_reg - 1'b1;
    assign popped   = pend_reg ? rd_data : '0;
    assign product  = popped * right_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Stack memory
    rpn_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (result_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Divider
    rpn_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (popped),
        .divisor  (right_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = is_operator(s_tdata) ? S_POPR : S_PUSH;
                end
            end
            S_POPR: state_next = S_POPL;
            S_POPL: state_next = S_CALC;
            S_CALC: state_next = div_start ? S_DIV : S_PUSH;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: state_next = last_reg ? S_FPOP : S_IDLE;
            S_FPOP: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, RAM ports, divider start
    always_comb
    begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = sp_dec[ADDR_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = sp_reg[ADDR_W-1:0];
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:                 s_tready  = 1'b1;
            S_POPR, S_POPL, S_FPOP: rd_en     = !sp_empty;
            S_CALC:                 div_start = (sym_reg == SYM_DIV) && (right_reg != '0);
            S_PUSH:                 wr_en     = !sp_full;
            S_DIV, S_EMIT:          ;
            default:                ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            uf_reg        <= 1'b0;
            of_reg        <= 1'b0;
            dz_reg        <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Load a new result, or drop the taken one
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_POPR, S_POPL, S_FPOP:
                begin
                    // Pop: an empty stack yields zero and flags underflow
                    if (sp_empty)
                    begin
                        uf_reg   <= 1'b1;
                        pend_reg <= 1'b0;
                    end
                    else
                    begin
                        sp_reg   <= sp_dec;
                        pend_reg <= 1'b1;
                    end
                end
                S_CALC:
                begin
                    if ((sym_reg == SYM_DIV) && (right_reg == '0))
                    begin
                        dz_reg <= 1'b1;
                    end
                end
                S_PUSH:
                begin
                    // Push: a full stack drops the value and flags overflow
                    if (sp_full)
                    begin
                        of_reg <= 1'b1;
                    end
                    else
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        sp_reg <= '0;
                        uf_reg <= 1'b0;
                        of_reg <= 1'b0;
                        dz_reg <= 1'b0;
                    end
                end
                S_IDLE, S_DIV: ;
                default:       ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sym_reg    <= s_tdata;
                    last_reg   <= s_tlast;
                    result_reg <= s_tdata - SYM_ZERO;
                end
            end
            S_POPL: right_reg <= popped;
            S_CALC:
            begin
                unique case (sym_reg)
                    SYM_ADD: result_reg <= popped + right_reg;
                    SYM_SUB: result_reg <= popped - right_reg;
                    SYM_MUL: result_reg <= product[WORD_W-1:0];
                    default: result_reg <= '0;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    result_reg <= div_q;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_value_reg <= popped;
                    out_flags_reg <= {dz_reg, of_reg, uf_reg};
                end
            end
            S_POPR, S_PUSH, S_FPOP: ;
            default:                ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_flags_reg;

endmodule

// ===== rtl/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rpn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser
);

    // Hold a stalled result in place
    `CHK_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
    `CHK_HOLD(a_out_stable, clk, rst_n, m_tvalid && !m_tready, {m_tdata, m_tuser}, "stalled result changed")

    // One symbol in work at a time: no accept right after an accept
    `CHK_ASSERT(a_one_item, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "second item taken while busy")

    // A symbol that is not the last one raises no result
    `CHK_ASSERT(a_no_spurious, clk, rst_n, (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid), "result without last symbol")

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/tb_postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking bench for the postfix evaluator. A short table of directed
// expressions comes first, then about a thousand symbols of random
// expressions: mostly well-formed, some deep enough to fill the stack, some
// broken and some pure byte noise. A behavioural model of the operand stack
// predicts every answer and flags, and each output item is compared with the
// oldest prediction while both sides idle and stall at random in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator
    import rpn_pkg::*;
();

    // Answer and flags of one expression
    typedef struct packed {
        logic [7:0] value;
        logic       underflow;
        logic       overflow;
        logic       divide_by_zero;
    } answer_t;

    // One row of the directed table; fixed rows carry a typed-in answer
    typedef struct packed {
        logic [7:0] sym;
        logic       lst;
        logic [5:0] reps;
        logic       fixed;
        answer_t    ans;
    } directed_t;

    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASE_ITEMS   = 140;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic [7:0] OPS [4] = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};

    // Idle patterns per phase: sender idle and receiver stall, in percent
    localparam int SEND_IDLE [4] = '{0, 80, 0, 11};
    localparam int RECV_IDLE [4] = '{0, 0, 80, 11};

    localparam directed_t DIRECTED [DIRECTED_ROWS] = '{
        // single pushes straight after reset, byte extremes
        '{SYM_ZERO + 8'd9, 1'b1, 6'd1, 1'b1, '{8'd9,  1'b0, 1'b0, 1'b0}},
        '{8'h00,           1'b1, 6'd1, 1'b1, '{8'hD0, 1'b0, 1'b0, 1'b0}},
        '{8'hFF,           1'b1, 6'd1, 1'b1, '{8'hCF, 1'b0, 1'b0, 1'b0}},
        // operators on an empty stack
        '{SYM_ADD,         1'b1, 6'd1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{SYM_DIV,         1'b1, 6'd1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
        // add, subtract, multiply
        '{SYM_ZERO + 8'd3, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_ZERO + 8'd4, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_ADD,         1'b1, 6'd1, 1'b0, '0},
        '{SYM_ZERO + 8'd7, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_ZERO + 8'd9, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_SUB,         1'b1, 6'd1, 1'b0, '0},
        '{SYM_ZERO + 8'd9, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_ZERO + 8'd9, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_MUL,         1'b1, 6'd1, 1'b0, '0},
        // divide by zero
        '{SYM_ZERO + 8'd5, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_ZERO,        1'b0, 6'd1, 1'b0, '0},
        '{SYM_DIV,         1'b1, 6'd1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
        // most negative over minus one wraps back to itself
        '{8'hB0,           1'b0, 6'd1, 1'b0, '0},
        '{SYM_ZERO,        1'b0, 6'd1, 1'b0, '0},
        '{SYM_ZERO + 8'd1, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_SUB,         1'b0, 6'd1, 1'b0, '0},
        '{SYM_DIV,         1'b1, 6'd1, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0}},
        // fill the stack, then one push too many
        '{SYM_ZERO + 8'd7, 1'b0, 6'd32, 1'b0, '0},
        '{SYM_ZERO + 8'd7, 1'b1, 6'd1,  1'b1, '{8'd7, 1'b0, 1'b1, 1'b0}},
        // second operand missing
        '{SYM_ZERO + 8'd5, 1'b0, 6'd1, 1'b0, '0},
        '{SYM_SUB,         1'b1, 6'd1, 1'b0, '0},
        // non-operator byte in the high half
        '{8'hC8,           1'b1, 6'd1, 1'b0, '0}
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] symbol
    logic       s_tlast;   // last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] value
    logic [2:0] m_tuser;   // [0] underflow, [1] overflow, [2] divide_by_zero

    // Behavioural copy of the evaluator state
    logic [7:0]  opnd_stack [STACK_DEPTH];
    int unsigned opnd_count;
    bit          uf_seen;
    bit          ov_seen;
    bit          dz_seen;

    answer_t expected_answers [$];
    int      mismatches;
    int      items_sent;
    int      send_idle_pct;
    int      stall_pct;

    postfix_expression_evaluator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pop an operand; an empty stack gives zero and marks underflow
    function automatic int pop_operand();
        if (opnd_count == 0)
        begin
            uf_seen = 1'b1;
            return 0;
        end
        opnd_count--;
        return int'($signed(opnd_stack[opnd_count]));
    endfunction

    // Push an operand; drop it and mark overflow when the stack is full
    function automatic void push_operand(input logic [7:0] v);
        if (opnd_count >= STACK_DEPTH)
            ov_seen = 1'b1;
        else
        begin
            opnd_stack[opnd_count] = v;
            opnd_count++;
        end
    endfunction

    // Advance the model by one symbol; on a last symbol return the answer
    function automatic void evaluate_symbol(input logic [7:0] sym, input logic lst,
                                            output bit emits, output answer_t ans);
        int rhs;
        int lhs;
        int res;
        emits = 1'b0;
        ans   = '0;
        if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL || sym == SYM_DIV)
        begin
            rhs = pop_operand();
            lhs = pop_operand();
            if (sym == SYM_ADD)
                res = lhs + rhs;
            else if (sym == SYM_SUB)
                res = lhs - rhs;
            else if (sym == SYM_MUL)
                res = lhs * rhs;
            else if (rhs == 0)
            begin
                dz_seen = 1'b1;
                res     = 0;
            end
            else
                res = lhs / rhs;
            push_operand(res[7:0]);
        end
        else
            push_operand(sym - SYM_ZERO);

        if (lst)
        begin
            res                = pop_operand();
            emits              = 1'b1;
            ans.value          = res[7:0];
            ans.underflow      = uf_seen;
            ans.overflow       = ov_seen;
            ans.divide_by_zero = dz_seen;
            opnd_count = 0;
            uf_seen    = 1'b0;
            ov_seen    = 1'b0;
            dz_seen    = 1'b0;
        end
    endfunction

    // Send one symbol: idle first, hold it until taken, then predict
    task automatic drive_symbol(input logic [7:0] sym, input logic lst,
                                input bit use_fixed, input answer_t fixed_ans);
        bit      emits;
        answer_t ans;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            s_tlast  <= 1'($urandom_range(1));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        evaluate_symbol(sym, lst, emits, ans);
        if (emits)
            expected_answers.push_back(use_fixed ? fixed_ans : ans);
        items_sent++;
        @(negedge clk);
    endtask

    // Operand byte: mostly a decimal digit, sometimes any byte
    function automatic logic [7:0] random_operand();
        if ($urandom_range(99) < 85)
            return SYM_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    // Build and send one random expression, last flag on its final symbol
    task automatic send_random_expression();
        logic [7:0] expr_q [$];
        int         kind;
        int         operands;
        int         depth;
        int         pos;
        bit         deep;
        kind = $urandom_range(99);
        deep = (kind >= 60 && kind < 70);
        if (kind >= 85)
        begin
            // noise: arbitrary bytes
            repeat ($urandom_range(8, 1))
                expr_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            operands = deep ? $urandom_range(36, 28) : $urandom_range(8, 1);
            depth    = 0;
            while (operands > 0 || depth > 1)
            begin
                if (depth >= 2 && (operands == 0 || (!deep && $urandom_range(1) == 1)))
                begin
                    expr_q.push_back(OPS[$urandom_range(3)]);
                    depth--;
                end
                else
                begin
                    expr_q.push_back(random_operand());
                    depth++;
                    operands--;
                end
            end
            // break a share of them: extra operator, extra operand or a gap
            if (kind >= 70)
            begin
                pos = $urandom_range(expr_q.size());
                case ($urandom_range(2))
                    0: expr_q.insert(pos, OPS[$urandom_range(3)]);
                    1: expr_q.insert(pos, random_operand());
                    default:
                        if (expr_q.size() > 1)
                            expr_q.delete($urandom_range(expr_q.size() - 1));
                endcase
            end
        end
        foreach (expr_q[i])
            drive_symbol(expr_q[i], i == expr_q.size() - 1, 1'b0, '0);
    endtask

    // Receiver readiness, redrawn every cycle
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each output item with the oldest prediction
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata, m_tuser[0], m_tuser[1], m_tuser[2]};
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result: value %0d flags %b", $signed(got.value), m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d",
                           $signed(want.value), $signed(got.value));
                    mismatches++;
                end
                if (got.underflow !== want.underflow)
                begin
                    $error("underflow: expected %b, got %b", want.underflow, got.underflow);
                    mismatches++;
                end
                if (got.overflow !== want.overflow)
                begin
                    $error("overflow: expected %b, got %b", want.overflow, got.overflow);
                    mismatches++;
                end
                if (got.divide_by_zero !== want.divide_by_zero)
                begin
                    $error("divide_by_zero: expected %b, got %b",
                           want.divide_by_zero, got.divide_by_zero);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int phase_end;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        opnd_count    = 0;
        uf_seen       = 1'b0;
        ov_seen       = 1'b0;
        dz_seen       = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[r])
            for (int k = 0; k < DIRECTED[r].reps; k++)
                drive_symbol(DIRECTED[r].sym, DIRECTED[r].lst && (k == DIRECTED[r].reps - 1),
                             DIRECTED[r].fixed, DIRECTED[r].ans);

        // random expressions, idling pattern changes per phase
        items_sent = 0;
        for (int ph = 0; items_sent < RANDOM_ITEMS; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph % 4];
            stall_pct     = RECV_IDLE[ph % 4];
            phase_end     = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < RANDOM_ITEMS)
                send_random_expression();
        end

        // drain
        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb_postfix_expression_evaluator OK");
        else
            $display("tb_postfix_expression_evaluator NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_postfix_expression_evaluator NOT OK");
        $finish;
    end

endmodule
